// ----- sv/mbcs_pkg.sv -----
`timescale 1ns / 1ps

package mbcs_pkg;

  // Largest matrix side that the block supports.
  localparam int MAX_DIM    = 16;
  localparam int CELLS      = MAX_DIM * MAX_DIM;
  localparam int BORDER_MAX = 4 * MAX_DIM;

  // Derived widths.
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int POS_W     = $clog2(CELLS + 1);
  localparam int ADDR_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int WALK_W    = $clog2(BORDER_MAX);
  localparam int DATA_W    = 32;
  localparam int REG_W     = 5;
  localparam int CFG_IDX_W = 1;

  // Request operation codes.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } cfg_reg_t;

  // One request.
  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] elem_value;
  } req_t;

  // One result.
  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic                     is_last;
  } res_t;

  // Control broadcast to every cell of the sorted chain.
  typedef struct packed {
    logic clear;
    logic insert;
  } chain_ctrl_t;

  // What one cell hands to its right-hand neighbor.
  typedef struct packed {
    logic                     keep;
    logic                     valid;
    logic signed [DATA_W-1:0] value;
  } cell_link_t;

endpackage

// ----- sv/mbcs_cell.sv -----
`timescale 1ns / 1ps

module mbcs_cell import mbcs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  chain_ctrl_t              ctrl,
  input  logic signed [DATA_W-1:0] key,
  input  cell_link_t               prev,
  output cell_link_t               link
);

  logic signed [DATA_W-1:0] value;
  logic                     valid;
  logic                     keep;

  // The cell keeps its entry when it holds a value at least as large as the new key.
  assign keep = valid && (value >= key);

  // Valid flag: cleared on restart, set when an entry moves in from the left.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.insert && !keep) begin
      valid <= prev.keep | prev.valid;
    end
  end

  // Entry: take the new key right after the last kept entry, else shift right.
  always_ff @(posedge clk) begin
    if (ctrl.insert && !keep) begin
      value <= prev.keep ? key : prev.value;
    end
  end

  assign link.keep  = keep;
  assign link.valid = valid;
  assign link.value = value;

endmodule

// ----- sv/mbcs_chain.sv -----
`timescale 1ns / 1ps

module mbcs_chain import mbcs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  chain_ctrl_t              ctrl,
  input  logic signed [DATA_W-1:0] key,
  input  logic [WALK_W-1:0]        sel,
  output logic signed [DATA_W-1:0] rd_value
);

  cell_link_t links [BORDER_MAX+1];

  // The left end acts as a full, kept entry so a new maximum lands in the first cell.
  assign links[0] = '{keep: 1'b1, valid: 1'b1, value: '0};

  // Row of cells, kept in descending order.
  for (genvar k = 0; k < BORDER_MAX; k++) begin : g_cell
    mbcs_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .key  (key),
      .prev (links[k]),
      .link (links[k+1])
    );
  end

  // Pick the entry at the walk position; an empty cell reads as zero.
  always_comb begin
    rd_value = '0;
    for (int k = 0; k < BORDER_MAX; k++) begin
      if (sel == WALK_W'(k) && links[k+1].valid) begin
        rd_value = links[k+1].value;
      end
    end
  end

endmodule

// ----- sv/matrix_border_clockwise_sort_unit.sv -----
`timescale 1ns / 1ps

// Channel   | Ports                         | Transfer
// ----------+-------------------------------+-----------------------------------
// request   | start, busy, request          | start high and busy low at an edge
// result    | done, result                  | done high for one cycle
// config    | cfg_we, cfg_index, cfg_data   | cfg_we high at an edge
//
// A request is taken in every cycle; busy stays low.
// A load writes the element to the matrix RAM and, on the border, inserts it
// into the sorted cell chain. A read gives its result through the registered RAM port
// and the first read stage, then the output register.
// Reset and any configuration write clear the counters and the chain valid bits;
// there is no clearing pass. The receiver cannot stall the results.

module matrix_border_clockwise_sort_unit import mbcs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 request,
  output logic                 done,
  output res_t                 result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  logic [REG_W-1:0]  row_count;
  logic [REG_W-1:0]  col_count;
  logic [DIM_W-1:0]  rows;
  logic [DIM_W-1:0]  cols;
  logic [IDX_W-1:0]  last_row;
  logic [IDX_W-1:0]  last_col;
  logic [POS_W-1:0]  total;

  logic [POS_W-1:0]  load_position;
  logic [IDX_W-1:0]  load_row;
  logic [IDX_W-1:0]  load_col;
  logic [POS_W-1:0]  read_position;
  logic [IDX_W-1:0]  read_row;
  logic [IDX_W-1:0]  read_col;

  logic              accept;
  logic              load_done;
  logic              load_go;
  logic              read_go;
  logic              load_border;
  logic              read_border;
  logic [WALK_W-1:0] walk;

  logic              s1_valid;
  logic              s1_border;
  logic              s1_last;
  logic [WALK_W-1:0] s1_walk;
  logic [DATA_W-1:0] mem_q;
  logic [DATA_W-1:0] matrix_store [CELLS];

  chain_ctrl_t              chain_ctrl;
  logic signed [DATA_W-1:0] border_value;

  // Every cycle can take a request.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Counts in use: zero acts as one, values above the maximum are clamped.
  always_comb begin
    if (row_count == '0) begin
      rows = DIM_W'(1);
    end else if (32'(row_count) > MAX_DIM) begin
      rows = DIM_W'(MAX_DIM);
    end else begin
      rows = DIM_W'(row_count);
    end
    if (col_count == '0) begin
      cols = DIM_W'(1);
    end else if (32'(col_count) > MAX_DIM) begin
      cols = DIM_W'(MAX_DIM);
    end else begin
      cols = DIM_W'(col_count);
    end
  end

  assign last_row  = IDX_W'(rows - DIM_W'(1));
  assign last_col  = IDX_W'(cols - DIM_W'(1));
  assign total     = POS_W'(POS_W'(rows) * POS_W'(cols));
  assign load_done = (load_position >= total);
  assign load_go   = accept && (request.op == OP_LOAD) && !load_done;
  assign read_go   = accept && (request.op == OP_READ) && load_done;

  // Border tests on the load and read positions.
  assign load_border = (load_row == '0) || (load_col == '0) ||
                       (load_row == last_row) || (load_col == last_col);
  assign read_border = (read_row == '0) || (read_col == '0) ||
                       (read_row == last_row) || (read_col == last_col);

  // Position along the clockwise walk from the top-left corner.
  always_comb begin
    if (read_row == '0) begin
      walk = WALK_W'(read_col);
    end else if (read_col == last_col) begin
      walk = WALK_W'(WALK_W'(last_col) + WALK_W'(read_row));
    end else if (read_row == last_row) begin
      walk = WALK_W'(WALK_W'(last_col) + WALK_W'(last_row) +
                     WALK_W'(last_col - read_col));
    end else begin
      walk = WALK_W'(WALK_W'(last_col) + WALK_W'(last_col) + WALK_W'(last_row) +
                     WALK_W'(last_row - read_row));
    end
  end

  // Configuration registers and position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= REG_W'(1);
      col_count     <= REG_W'(1);
      load_position <= '0;
      load_row      <= '0;
      load_col      <= '0;
      read_position <= '0;
      read_row      <= '0;
      read_col      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_ROW_COUNT) begin
        row_count <= cfg_data;
      end else begin
        col_count <= cfg_data;
      end
      load_position <= '0;
      load_row      <= '0;
      load_col      <= '0;
      read_position <= '0;
      read_row      <= '0;
      read_col      <= '0;
    end else begin
      if (load_go) begin
        load_position <= load_position + POS_W'(1);
        if (load_col == last_col) begin
          load_col <= '0;
          load_row <= load_row + IDX_W'(1);
        end else begin
          load_col <= load_col + IDX_W'(1);
        end
      end
      if (read_go) begin
        if (read_position == total - POS_W'(1)) begin
          read_position <= '0;
          read_row      <= '0;
          read_col      <= '0;
        end else begin
          read_position <= read_position + POS_W'(1);
          if (read_col == last_col) begin
            read_col <= '0;
            read_row <= read_row + IDX_W'(1);
          end else begin
            read_col <= read_col + IDX_W'(1);
          end
        end
      end
    end
  end

  // Matrix RAM: one write port for loads, one registered read port for reads.
  always_ff @(posedge clk) begin
    if (load_go) begin
      matrix_store[load_position[ADDR_W-1:0]] <= request.elem_value;
    end
    if (read_go) begin
      mem_q <= matrix_store[read_position[ADDR_W-1:0]];
    end
  end

  // Sorted chain of border values.
  assign chain_ctrl.clear  = cfg_we;
  assign chain_ctrl.insert = load_go && load_border;

  mbcs_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (chain_ctrl),
    .key      (request.elem_value),
    .sel      (s1_walk),
    .rd_value (border_value)
  );

  // First read stage: walk position, border flag and last flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= read_go;
    end
    if (read_go) begin
      s1_border <= read_border;
      s1_walk   <= walk;
      s1_last   <= (read_position == total - POS_W'(1));
    end
  end

  // Output register: border cells from the chain, interior cells from the RAM.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    if (s1_valid) begin
      result.out_value <= s1_border ? border_value : mem_q;
      result.is_last   <= s1_last;
    end
  end

endmodule

// ----- tb/sv/mbcs_border_checker.sv -----
`timescale 1ns / 1ps

module mbcs_border_checker import mbcs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  req_t                 request,
  input  logic                 done,
  input  res_t                 result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output int                   mismatch_count,
  output int                   pending_count
);

  // Shadow copy of the registers and of the matrix as the block should hold it.
  logic [REG_W-1:0]         row_reg;
  logic [REG_W-1:0]         col_reg;
  logic signed [DATA_W-1:0] cell_store [CELLS];
  logic signed [DATA_W-1:0] border_desc [$];
  int                       loaded_cells;
  int                       read_cell;
  res_t                     expected_elems [$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  // A count of zero acts as one; anything past the largest side acts as that side.
  function automatic int clamp_dim(logic [REG_W-1:0] code);
    if (code == 0) return 1;
    if (code > MAX_DIM) return MAX_DIM;
    return int'(code);
  endfunction

  function automatic bit is_border_cell(int i, int j, int rows, int cols);
    return i == 0 || j == 0 || i == rows - 1 || j == cols - 1;
  endfunction

  // Position of a border cell along the clockwise walk from the top-left corner.
  function automatic int clockwise_index(int i, int j, int rows, int cols);
    if (i == 0) return j;
    if (j == cols - 1) return cols - 1 + i;
    if (i == rows - 1) return (cols - 1) + (rows - 1) + (cols - 1 - j);
    return 2 * (cols - 1) + (rows - 1) + (rows - 1 - i);
  endfunction

  task automatic clear_matrix();
    border_desc.delete();
    loaded_cells = 0;
    read_cell    = 0;
  endtask

  // Keep the border values in descending order; equal values go after older ones.
  task automatic insert_border_value(logic signed [DATA_W-1:0] value);
    int k = 0;
    if (border_desc.size() >= BORDER_MAX) return;
    while (k < border_desc.size() && border_desc[k] >= value) k++;
    border_desc.insert(k, value);
  endtask

  // Update the shadow matrix for one request and queue the element a read should give.
  task automatic apply_request(req_t rq);
    int   rows;
    int   cols;
    int   total;
    int   pos;
    int   i;
    int   j;
    int   w;
    res_t exp_res;
    rows  = clamp_dim(row_reg);
    cols  = clamp_dim(col_reg);
    total = rows * cols;
    if (rq.op == OP_LOAD) begin
      if (loaded_cells < total) begin
        cell_store[loaded_cells] = rq.elem_value;
        if (is_border_cell(loaded_cells / cols, loaded_cells % cols, rows, cols))
          insert_border_value(rq.elem_value);
        loaded_cells++;
      end
    end else if (loaded_cells >= total) begin
      pos = (read_cell >= total) ? 0 : read_cell;
      i   = pos / cols;
      j   = pos % cols;
      if (is_border_cell(i, j, rows, cols)) begin
        w = clockwise_index(i, j, rows, cols);
        exp_res.out_value = (w < border_desc.size()) ? border_desc[w] : '0;
      end else begin
        exp_res.out_value = cell_store[pos];
      end
      exp_res.is_last = (pos == total - 1);
      expected_elems.push_back(exp_res);
      read_cell = (pos + 1 >= total) ? 0 : pos + 1;
    end
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    res_t exp_res;
    if (rst) begin
      row_reg = REG_W'(1);
      col_reg = REG_W'(1);
      clear_matrix();
      expected_elems.delete();
    end else begin
      // Compare each result with the oldest element still owed.
      if (done) begin
        if (expected_elems.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with none expected: out_value %0d is_last %0b",
                     $time, result.out_value, result.is_last);
        end else begin
          exp_res = expected_elems.pop_front();
          if (result.out_value !== exp_res.out_value || result.is_last !== exp_res.is_last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: expected out_value %0d is_last %0b, got out_value %0d is_last %0b",
                       $time, exp_res.out_value, exp_res.is_last,
                       result.out_value, result.is_last);
          end
        end
      end

      // Any register write restarts the matrix.
      if (cfg_we) begin
        if (cfg_index == REG_ROW_COUNT) begin
          row_reg = cfg_data;
        end else begin
          col_reg = cfg_data;
        end
        clear_matrix();
      end

      if (start && !busy)
        apply_request(request);
    end
    pending_count = expected_elems.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import mbcs_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int SETTLE_CYCLES = 4;
  localparam int ITEMS_PER_PHASE = 300;
  localparam logic signed [DATA_W-1:0] ELEM_MIN = {1'b1, {(DATA_W - 1){1'b0}}};
  localparam logic signed [DATA_W-1:0] ELEM_MAX = {1'b0, {(DATA_W - 1){1'b1}}};

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  req_t                 request   = '0;
  logic                 done;
  res_t                 result;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data  = '0;
  int                   mismatch_count;
  int                   pending_count;
  int                   idle_pct  = 31;
  int                   counted_items = 0;

  matrix_border_clockwise_sort_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mbcs_border_checker border_chk (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .request        (request),
    .done           (done),
    .result         (result),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always #HALF_PERIOD clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #(2_000_000);
    $display("Mismatches found");
    $finish;
  end

  // Drive one request at the falling edge, with random idle cycles first,
  // and hold it until the block takes it.
  task automatic send_request(op_t op, logic signed [DATA_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      start              <= 1'b0;
      request.elem_value <= $urandom;
      @(negedge clk);
    end
    start   <= 1'b1;
    request <= '{op, value};
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and let every owed element come out, then wait SETTLE_CYCLES for a last load.
  task automatic settle();
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write both dimension registers back to back, in random order.
  task automatic set_dims(logic [REG_W-1:0] rows_code, logic [REG_W-1:0] cols_code);
    bit row_first;
    row_first = 1'($urandom_range(1));
    cfg_we    <= 1'b1;
    cfg_index <= row_first ? REG_ROW_COUNT : REG_COL_COUNT;
    cfg_data  <= row_first ? rows_code : cols_code;
    @(negedge clk);
    cfg_index <= row_first ? REG_COL_COUNT : REG_ROW_COUNT;
    cfg_data  <= row_first ? cols_code : rows_code;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Element values lean toward the extremes and toward small values that repeat.
  function automatic logic signed [DATA_W-1:0] pick_elem();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return ELEM_MIN;
    if (sel == 1) return ELEM_MAX;
    if (sel < 5) return $urandom_range(6) - 3;
    return $urandom;
  endfunction

  // Mostly small sides, with single lines and the full size now and then.
  function automatic int pick_dim();
    int sel;
    sel = $urandom_range(99);
    if (sel < 12) return 1;
    if (sel < 20) return MAX_DIM;
    if (sel < 30) return $urandom_range(MAX_DIM - 1, 6);
    return $urandom_range(5, 2);
  endfunction

  // Register code for a side; out-of-range codes stand in for one and for the full size.
  function automatic logic [REG_W-1:0] dim_code(int dim);
    if (dim == 1 && $urandom_range(2) == 0) return '0;
    if (dim == MAX_DIM && $urandom_range(1) == 0)
      return REG_W'($urandom_range((1 << REG_W) - 1, MAX_DIM + 1));
    return REG_W'(dim);
  endfunction

  // Load one matrix and read it back, sometimes more than once around.
  task automatic run_matrix(int rows, int cols);
    int total;
    int loads;
    int reads;
    total = rows * cols;
    // Now and then the matrix is left partly loaded and the next write restarts it.
    loads = ($urandom_range(9) == 0) ? $urandom_range(total - 1) : total;
    if ($urandom_range(3) == 0) send_request(OP_READ, $urandom);
    for (int n = 0; n < loads; n++) begin
      send_request(OP_LOAD, pick_elem());
      if ($urandom_range(19) == 0) send_request(OP_READ, $urandom);
    end
    counted_items += loads;
    if (loads < total) return;
    reads = total * $urandom_range(2, 1) + $urandom_range(total);
    for (int n = 0; n < reads; n++) begin
      send_request(OP_READ, $urandom);
      if ($urandom_range(29) == 0) send_request(OP_LOAD, $urandom);
    end
    counted_items += reads;
  endtask

  initial begin
    logic signed [DATA_W-1:0] ring_vals [9];
    int rows;
    int cols;
    ring_vals = '{ELEM_MIN, ELEM_MAX, 0, 7, -1, 32'sh5555_5555, 7, 32'shAAAA_AAAA, -7};

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // A single element after reset: read before loading, wrap, and a load past the end.
    send_request(OP_READ, 0);
    send_request(OP_LOAD, ELEM_MIN);
    send_request(OP_READ, '1);
    send_request(OP_READ, 0);
    send_request(OP_LOAD, ELEM_MAX);
    send_request(OP_READ, 0);
    settle();

    // A 3x3 matrix with extremes and duplicates on the ring around one interior cell.
    set_dims(REG_W'(3), REG_W'(3));
    foreach (ring_vals[k]) send_request(OP_LOAD, ring_vals[k]);
    repeat (10) send_request(OP_READ, 0);

    // Random matrices under three idle settings.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 31 : (phase == 1) ? 62 : 0;
      while (counted_items < (phase + 1) * ITEMS_PER_PHASE) begin
        rows = pick_dim();
        cols = pick_dim();
        settle();
        set_dims(dim_code(rows), dim_code(cols));
        run_matrix(rows, cols);
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
